>>> rtl/core/hcfs_pkg.sv
// Shared types, constants and the CRC-16 byte update for the header CRC frame sync.
`default_nettype none

package hcfs_pkg;

  localparam int unsigned FrameLenDef = 32;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned ByteIdxW    = 6;
  localparam int unsigned CrcW        = 16;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [CrcW-1:0]  CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly = 16'h8408;

  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'h47;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h44;

  localparam logic [CfgIdxW-1:0] RegHeaderFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderSecond = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_CRC    = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  // Reflected CRC-16 update over one byte, one shift step per bit.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/header_crc_frame_sync.sv
// Header synchronized deframer with CRC-16 check over a circular frame buffer.
//
//  Channel  Signals                                        Direction
//  in       in_valid_i, in_stall_o, in_byte_i              request in
//  out      out_valid_o, out_stall_i, frame_byte_o,        request out
//           byte_index_o, last_byte_o
//  cfg      cfg_valid_i, cfg_ready_o, cfg_index_i,         register write in
//           cfg_data_i
//
// A byte is taken only while idle. The header search then reads the
// buffer through its single read port, one entry a cycle. A full candidate
// is checked by CRC one byte a cycle; a CRC miss drops one byte and
// rescans. A good frame is sent byte by byte, each byte read from the buffer
// before it is sent, and a stalled output holds it. Reset clears control
// state only; the buffer needs no clearing pass. The last result may wait
// in the output register while the next byte is accepted.
`default_nettype none

module header_crc_frame_sync #(
  parameter int unsigned FRAME_LEN = hcfs_pkg::FrameLenDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [hcfs_pkg::ByteW-1:0]    in_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [hcfs_pkg::ByteW-1:0]         frame_byte_o,
  output logic [hcfs_pkg::ByteIdxW-1:0]      byte_index_o,
  output logic                               last_byte_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hcfs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hcfs_pkg::ByteW-1:0]    cfg_data_i
);

  import hcfs_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_LEN);
  localparam int unsigned CW = $clog2(FRAME_LEN + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [CW-1:0] FillFull = CW'(FRAME_LEN);
  localparam logic [CW-1:0] LastCnt  = CW'(FRAME_LEN - 1);
  localparam logic [CW-1:0] RxLoCnt  = CW'(FRAME_LEN - 2);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(FRAME_LEN)) begin
      s = s - SW'(FRAME_LEN);
    end
    return s[AW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [ByteW-1:0] hdr_first_q, hdr_second_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    ra_q, ra_d;
  logic             dv_q, dv_d;
  logic [CW-1:0]    dcnt_q, dcnt_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] prev_q, prev_d;
  logic [ByteW-1:0] rxlo_q, rxlo_d;
  logic [ByteW-1:0] rdata_q;

  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_byte_q, out_byte_d;
  logic [ByteIdxW-1:0] out_idx_q, out_idx_d;
  logic                out_last_q, out_last_d;

  logic [ByteW-1:0] mem_q [FRAME_LEN];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;

  logic [AW-1:0] head_n;
  logic [CW-1:0] fill_n;
  logic [CW-1:0] skip;
  logic          out_free;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign byte_index_o = out_idx_q;
  assign last_byte_o  = out_last_q;
  assign out_free     = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    ra_d        = ra_q;
    dv_d        = 1'b0;
    dcnt_d      = cnt_q;
    crc_d       = crc_q;
    prev_d      = prev_q;
    rxlo_d      = rxlo_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_wa      = wrap_add(head_q, fill_q);
    head_n      = head_q;
    fill_n      = fill_q;
    skip        = dcnt_q - CW'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mem_we = 1'b1;
          if (fill_q == FillFull) begin
            // Guard only: the oldest byte gives way to the new one.
            mem_wa = head_q;
            head_n = wrap_add(head_q, CW'(1));
            fill_n = fill_q;
          end else begin
            fill_n = fill_q + CW'(1);
          end
          head_d = head_n;
          fill_d = fill_n;
          if (fill_n >= CW'(2)) begin
            state_d = ST_SEARCH;
            ra_d    = head_n;
            cnt_d   = '0;
          end
        end
      end

      ST_SEARCH: begin
        if (cnt_q < fill_q) begin
          dv_d  = 1'b1;
          ra_d  = wrap_add(ra_q, CW'(1));
          cnt_d = cnt_q + CW'(1);
        end
        if (dv_q) begin
          prev_d = rdata_q;
          if ((dcnt_q != '0) && (prev_q == hdr_first_q) && (rdata_q == hdr_second_q)) begin
            // Earliest header found: drop everything in front of it.
            head_n = wrap_add(head_q, skip);
            fill_n = fill_q - skip;
            head_d = head_n;
            fill_d = fill_n;
            dv_d   = 1'b0;
            cnt_d  = '0;
            ra_d   = head_n;
            crc_d  = CrcInit;
            state_d = (fill_n == FillFull) ? ST_CRC : ST_IDLE;
          end else if (dcnt_q == fill_q - CW'(1)) begin
            // No header anywhere; a trailing first header byte survives.
            if (rdata_q == hdr_first_q) begin
              head_d = wrap_add(head_q, fill_q - CW'(1));
              fill_d = CW'(1);
            end else begin
              fill_d = '0;
            end
            state_d = ST_IDLE;
          end
        end
      end

      ST_CRC: begin
        if (cnt_q < FillFull) begin
          dv_d  = 1'b1;
          ra_d  = wrap_add(ra_q, CW'(1));
          cnt_d = cnt_q + CW'(1);
        end
        if (dv_q) begin
          if (dcnt_q < RxLoCnt) begin
            crc_d = crc_byte(crc_q, rdata_q);
          end else if (dcnt_q == RxLoCnt) begin
            rxlo_d = rdata_q;
          end else begin
            dv_d  = 1'b0;
            cnt_d = '0;
            if ({rdata_q, rxlo_q} == crc_q) begin
              ra_d    = head_q;
              state_d = ST_EMIT;
            end else begin
              head_n  = wrap_add(head_q, CW'(1));
              head_d  = head_n;
              fill_d  = fill_q - CW'(1);
              ra_d    = head_n;
              state_d = ST_SEARCH;
            end
          end
        end
      end

      ST_EMIT: begin
        // The read address holds until its byte is sent, so the read data stays put.
        dv_d = 1'b1;
        if (dv_q && out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rdata_q;
          out_idx_d   = ByteIdxW'(cnt_q);
          out_last_d  = (cnt_q == LastCnt);
          dv_d        = 1'b0;
          if (cnt_q == LastCnt) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            ra_d  = wrap_add(ra_q, CW'(1));
            cnt_d = cnt_q + CW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
      head_q       <= '0;
      fill_q       <= '0;
      cnt_q        <= '0;
      ra_q         <= '0;
      dv_q         <= 1'b0;
      dcnt_q       <= '0;
      crc_q        <= CrcInit;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      ra_q        <= ra_d;
      dv_q        <= dv_d;
      dcnt_q      <= dcnt_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == RegHeaderFirst) begin
          hdr_first_q <= cfg_data_i;
        end else if (cfg_index_i == RegHeaderSecond) begin
          hdr_second_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    rxlo_q     <= rxlo_d;
    out_byte_q <= out_byte_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= in_byte_i;
    end
    rdata_q <= mem_q[ra_q];
  end

endmodule

`default_nettype wire
